// ----- rtl/sps_pkg.sv -----
// Package for the segment proximity shader.
// Holds widths, register indexes and the segment record type; no dependencies.
`timescale 1ns / 1ps
package sps_pkg;

    localparam int MAX_SEG    = 64;
    localparam int COORD_BITS = 16;
    localparam int WIDTH_BITS = 15;
    localparam int COLOR_BITS = 32;
    localparam int LCNT_BITS  = 7;
    localparam int IDX_BITS   = 6;
    localparam int CFG_ABITS  = 2;
    localparam int CFG_DBITS  = 32;

    // register indexes
    localparam logic [CFG_ABITS-1:0] REG_WIRE_COLOR = 2'd0;
    localparam logic [CFG_ABITS-1:0] REG_BASE_COLOR = 2'd1;
    localparam logic [CFG_ABITS-1:0] REG_WIRE_WIDTH = 2'd2;
    localparam logic [CFG_ABITS-1:0] REG_LINE_COUNT = 2'd3;

    // arithmetic widths of the distance test, all exact
    localparam int VB  = COORD_BITS + 1;      // P - O
    localparam int PB  = VB + COORD_BITS;     // one product
    localparam int NB  = PB + 2;              // sum of three products
    localparam int XB  = PB + 1;              // cross component
    localparam int SQB = 2 * XB;              // squared cross component
    localparam int LB  = SQB + 2;             // squared distance times d
    localparam int W2B = 2 * WIDTH_BITS;      // width squared
    localparam int RB  = W2B + NB;            // width squared times d
    localparam int CMB = (LB > RB ? LB : RB) + 1;

    // drain cycles of the test pipeline plus margin
    localparam int PIPE_DEPTH = 8;
    localparam int RUN_LEN    = MAX_SEG + PIPE_DEPTH;
    localparam int CNT_BITS   = $clog2(RUN_LEN + 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ox;
        logic signed [COORD_BITS-1:0] oy;
        logic signed [COORD_BITS-1:0] oz;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
        logic signed [COORD_BITS-1:0] dz;
    } t_seg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
    } t_point;

    // control between sequencer and ring cells
    typedef struct packed {
        logic                shift;
        logic                load;
        logic [IDX_BITS-1:0] idx;
    } t_ring_ctl;

endpackage

// ----- rtl/sps_cell.sv -----
// One cell of the segment ring: holds a segment, loads it or takes its neighbour's.
// Depends on sps_pkg.
`timescale 1ns / 1ps
module sps_cell
    import sps_pkg::*;
(
    input  logic      i_clk,
    input  t_ring_ctl i_ctl,
    input  logic      i_sel,
    input  t_seg      i_load_seg,
    input  t_seg      i_next_seg,
    output t_seg      o_seg
);

    t_seg r_seg;

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_seg <= i_next_seg;
        end else if (i_ctl.load && i_sel) begin
            r_seg <= i_load_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

// ----- rtl/sps_dist.sv -----
// Pipelined exact point-to-segment distance test, one segment per cycle.
// Depends on sps_pkg.
`timescale 1ns / 1ps
module sps_dist
    import sps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_seg                 i_seg,
    input  t_point               i_pt,
    input  logic [W2B-1:0]       i_w2,
    output logic                 o_valid,
    output logic                 o_hit
);

    // stage 1: V = P - O
    logic                  r_v1;
    logic signed [VB-1:0]  r_vx, r_vy, r_vz;
    logic signed [COORD_BITS-1:0] r_dx1, r_dy1, r_dz1;
    // stage 2: products
    logic                  r_v2;
    logic signed [PB-1:0]  r_nx, r_ny, r_nz, r_qx, r_qy, r_qz;
    logic signed [PB-1:0]  r_a1, r_a2, r_b1, r_b2, r_c1, r_c2;
    // stage 3: sums and cross components
    logic                  r_v3;
    logic signed [NB-1:0]  r_n, r_d3;
    logic signed [XB-1:0]  r_cx, r_cy, r_cz;
    // stage 4: squares, range checks
    logic                  r_v4, r_ok4;
    logic signed [SQB-1:0] r_sx, r_sy, r_sz;
    logic [RB-1:0]         r_rhs;
    // stage 5: result
    logic                  r_v5, r_hit5;

    logic [LB-1:0]         n_lhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign n_lhs = LB'($unsigned(r_sx)) + LB'($unsigned(r_sy)) + LB'($unsigned(r_sz));

    always_ff @(posedge i_clk) begin
        // difference vector
        r_vx  <= VB'(i_pt.px) - VB'(i_seg.ox);
        r_vy  <= VB'(i_pt.py) - VB'(i_seg.oy);
        r_vz  <= VB'(i_pt.pz) - VB'(i_seg.oz);
        r_dx1 <= i_seg.dx;
        r_dy1 <= i_seg.dy;
        r_dz1 <= i_seg.dz;
        // dot, length and cross partial products
        r_nx <= r_vx * r_dx1;
        r_ny <= r_vy * r_dy1;
        r_nz <= r_vz * r_dz1;
        r_qx <= r_dx1 * r_dx1;
        r_qy <= r_dy1 * r_dy1;
        r_qz <= r_dz1 * r_dz1;
        r_a1 <= r_vy * r_dz1;
        r_a2 <= r_vz * r_dy1;
        r_b1 <= r_vz * r_dx1;
        r_b2 <= r_vx * r_dz1;
        r_c1 <= r_vx * r_dy1;
        r_c2 <= r_vy * r_dx1;
        // sums
        r_n  <= NB'(r_nx) + NB'(r_ny) + NB'(r_nz);
        r_d3 <= NB'(r_qx) + NB'(r_qy) + NB'(r_qz);
        r_cx <= XB'(r_a1) - XB'(r_a2);
        r_cy <= XB'(r_b1) - XB'(r_b2);
        r_cz <= XB'(r_c1) - XB'(r_c2);
        // squares; foot must lie on the segment and d non-zero
        r_sx  <= r_cx * r_cx;
        r_sy  <= r_cy * r_cy;
        r_sz  <= r_cz * r_cz;
        r_rhs <= RB'(i_w2) * RB'($unsigned(r_d3));
        r_ok4 <= (r_d3 != '0) && !r_n[NB-1] && (r_n <= r_d3);
        // distance compare, strictly below
        r_hit5 <= r_ok4 && (CMB'(n_lhs) < CMB'(r_rhs));
    end

    assign o_valid = r_v5;
    assign o_hit   = r_hit5;

endmodule

// ----- rtl/segment_proximity_shader.sv -----
// Segment proximity shader: a ring of segment cells rotating past one distance unit.
// A query runs from acceptance through one full ring rotation (one active segment tested
// per cycle) and the draining of the pipeline. Loads are accepted only while idle.
// One query at a time, so a new query is taken only after the last one has finished;
// loads are accepted while a result waits, and a waiting result stalls the next query.
// Synchronous active-low reset clears control and configuration; table is undefined.
`timescale 1ns / 1ps
module segment_proximity_shader
    import sps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_ABITS-1:0] i_cfg_addr,
    input  logic [CFG_DBITS-1:0] i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // line_index, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // point_x, point_y, point_z, zero pad
    input  logic [151:0]         s_axis_tdata,
    // action
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // color
    output logic [31:0]          m_axis_tdata,
    // hit
    output logic                 m_axis_tuser
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    localparam int CB = COORD_BITS;

    t_state                 r_state;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_acc;
    logic                   r_m_valid;
    logic [COLOR_BITS-1:0]  r_m_color;
    logic                   r_m_hit;
    logic [COLOR_BITS-1:0]  r_wire_color, r_base_color;
    logic [WIDTH_BITS-1:0]  r_wire_width;
    logic [LCNT_BITS-1:0]   r_line_count;
    logic [W2B-1:0]         r_w2;
    t_point                 r_pt;
    t_seg                   r_head;
    logic                   r_issue;

    t_seg                   w_load_seg;
    t_seg                   w_cell [MAX_SEG];
    t_ring_ctl              w_ctl;
    logic                   w_in_acc, w_out_acc, w_last, w_done;
    logic [LCNT_BITS:0]     w_n_eff;
    logic                   w_dv, w_dh;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = r_m_valid && m_axis_tready;
    assign w_last    = (r_cnt == CNT_BITS'(RUN_LEN - 1));
    assign w_done    = (r_state == S_RUN) && w_last && (!r_m_valid || w_out_acc);

    assign w_load_seg.ox = s_axis_tdata[IDX_BITS+0*CB +: CB];
    assign w_load_seg.oy = s_axis_tdata[IDX_BITS+1*CB +: CB];
    assign w_load_seg.oz = s_axis_tdata[IDX_BITS+2*CB +: CB];
    assign w_load_seg.dx = s_axis_tdata[IDX_BITS+3*CB +: CB];
    assign w_load_seg.dy = s_axis_tdata[IDX_BITS+4*CB +: CB];
    assign w_load_seg.dz = s_axis_tdata[IDX_BITS+5*CB +: CB];

    // ring control: rotate while the run counter is below MAX_SEG
    assign w_ctl.shift = (r_state == S_RUN) && (r_cnt < CNT_BITS'(MAX_SEG));
    assign w_ctl.load  = w_in_acc && !s_axis_tuser;
    assign w_ctl.idx   = s_axis_tdata[IDX_BITS-1:0];

    // saturated segment count
    assign w_n_eff = (r_line_count > LCNT_BITS'(MAX_SEG)) ? (LCNT_BITS+1)'(MAX_SEG)
                                                          : (LCNT_BITS+1)'(r_line_count);

    genvar g;
    generate
        for (g = 0; g < MAX_SEG; g++) begin : g_ring
            sps_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_sel      (w_ctl.idx == IDX_BITS'(g)),
                .i_load_seg (w_load_seg),
                .i_next_seg (w_cell[(g + 1) % MAX_SEG]),
                .o_seg      (w_cell[g])
            );
        end
    endgenerate

    // head of ring feeds the distance unit
    always_ff @(posedge i_clk) begin
        r_head <= w_cell[0];
        r_w2   <= W2B'(r_wire_width) * W2B'(r_wire_width);
        if (w_in_acc && s_axis_tuser) begin
            r_pt.px <= s_axis_tdata[IDX_BITS+6*CB +: CB];
            r_pt.py <= s_axis_tdata[IDX_BITS+7*CB +: CB];
            r_pt.pz <= s_axis_tdata[IDX_BITS+8*CB +: CB];
        end
    end

    sps_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_issue),
        .i_seg   (r_head),
        .i_pt    (r_pt),
        .i_w2    (r_w2),
        .o_valid (w_dv),
        .o_hit   (w_dh)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wire_color <= '1;
            r_base_color <= '0;
            r_wire_width <= WIDTH_BITS'(256);
            r_line_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WIRE_COLOR: r_wire_color <= i_cfg_data[COLOR_BITS-1:0];
                REG_BASE_COLOR: r_base_color <= i_cfg_data[COLOR_BITS-1:0];
                REG_WIRE_WIDTH: r_wire_width <= i_cfg_data[WIDTH_BITS-1:0];
                REG_LINE_COUNT: r_line_count <= i_cfg_data[LCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // query sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_acc     <= 1'b0;
            r_issue   <= 1'b0;
            r_m_valid <= 1'b0;
            r_m_color <= '0;
            r_m_hit   <= 1'b0;
        end else begin
            // output register: take a finished query, else drop a sent transaction
            if (w_done) begin
                r_m_valid <= 1'b1;
                r_m_hit   <= r_acc;
                r_m_color <= r_acc ? r_wire_color : r_base_color;
            end else if (w_out_acc) begin
                r_m_valid <= 1'b0;
            end
            r_issue <= (r_state == S_RUN) && ((LCNT_BITS+1 > CNT_BITS ?
                       (LCNT_BITS+1)'(r_cnt) < w_n_eff :
                       r_cnt < CNT_BITS'(w_n_eff)));
            // hit accumulator, cleared when a query is taken
            if (w_in_acc && s_axis_tuser) begin
                r_acc <= 1'b0;
            end else if (w_dv && w_dh) begin
                r_acc <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && s_axis_tuser) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                    end
                end
                S_RUN: begin
                    if (!w_last) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_color;
    assign m_axis_tuser  = r_m_hit;

endmodule

// ----- rtl/sps_checker.sv -----
// Port-level checks for the segment proximity shader, bound to the top level.
// Depends on sps_pkg and segment_proximity_shader.
`timescale 1ns / 1ps
module sps_checker
    import sps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a query transaction makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("input ready during a query");

    // a new result only appears at the end of a query
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a running query");

    // nothing pending straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid after reset");

endmodule

bind segment_proximity_shader sps_checker u_sps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/testbench.sv -----
// Self-checking bench for the segment proximity shader: directed and random stimulus,
// an exact integer predictor of each query result, and a per-transaction checker.
// Depends on rtl/sps_pkg.sv and rtl/segment_proximity_shader.sv.
`timescale 1ns / 1ps
module testbench;
    import sps_pkg::*;

    typedef struct {
        logic [31:0] color;
        logic        hit;
    } t_shade;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_ABITS-1:0] i_cfg_addr;
    logic [CFG_DBITS-1:0] i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [151:0]         s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;
    logic                 m_axis_tuser;

    // shadow of the block's state
    logic signed [15:0] tab_org [MAX_SEG][3];
    logic signed [15:0] tab_dir [MAX_SEG][3];
    logic [31:0] sh_wire_color;
    logic [31:0] sh_base_color;
    logic [14:0] sh_wire_width;
    logic [6:0]  sh_line_count;

    t_shade shade_q[$];
    int     err_count;
    bit     no_idle;
    int     out_stall;

    segment_proximity_shader u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // exact point-to-segment test on one table slot
    function automatic bit seg_near(int slot, logic signed [15:0] pt [3]);
        logic signed [127:0] v [3];
        logic signed [127:0] dv [3];
        logic signed [127:0] d, n, cx, cy, cz, lhs, rhs, w;
        for (int k = 0; k < 3; k++) begin
            v[k]  = pt[k];
            v[k]  = v[k] - tab_org[slot][k];
            dv[k] = tab_dir[slot][k];
        end
        d = dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2];
        n = v[0] * dv[0] + v[1] * dv[1] + v[2] * dv[2];
        if (d == 0 || n < 0 || n > d) return 1'b0;
        cx  = v[1] * dv[2] - v[2] * dv[1];
        cy  = v[2] * dv[0] - v[0] * dv[2];
        cz  = v[0] * dv[1] - v[1] * dv[0];
        lhs = cx * cx + cy * cy + cz * cz;
        w   = {113'd0, sh_wire_width};
        rhs = w * w * d;
        return lhs < rhs;
    endfunction

    function automatic t_shade shade_point(logic signed [15:0] pt [3]);
        t_shade r;
        int     cnt;
        bit     h;
        cnt = (sh_line_count > MAX_SEG) ? MAX_SEG : sh_line_count;
        h = 1'b0;
        for (int i = 0; i < cnt && !h; i++) h = seg_near(i, pt);
        r.hit   = h;
        r.color = h ? sh_wire_color : sh_base_color;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // one transaction on the input stream; prediction at acceptance
    task automatic send_item(logic act, int slot, logic signed [15:0] org [3],
                             logic signed [15:0] dir [3], logic signed [15:0] pt [3]);
        int gap;
        bit done;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, pt[2], pt[1], pt[0], dir[2], dir[1], dir[0],
                          org[2], org[1], org[0], slot[5:0]};
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            if (s_axis_tready) done = 1'b1;
        end
        if (act == ACT_LOAD) begin
            for (int k = 0; k < 3; k++) begin
                tab_org[slot][k] = org[k];
                tab_dir[slot][k] = dir[k];
            end
        end else begin
            shade_q.push_back(shade_point(pt));
        end
        @(negedge i_clk);
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic load_seg(int slot, logic signed [15:0] org [3],
                            logic signed [15:0] dir [3]);
        logic signed [15:0] pt [3];
        foreach (pt[k]) pt[k] = $urandom;
        send_item(ACT_LOAD, slot, org, dir, pt);
    endtask

    task automatic query_pt(logic signed [15:0] pt [3]);
        logic signed [15:0] junk_o [3];
        logic signed [15:0] junk_d [3];
        foreach (junk_o[k]) begin
            junk_o[k] = $urandom;
            junk_d[k] = $urandom;
        end
        send_item(ACT_QUERY, $urandom_range(0, 63), junk_o, junk_d, pt);
    endtask

    // wait until every result is in and the block has drained
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (shade_q.size() != 0) @(negedge i_clk);
        repeat (RUN_LEN + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ABITS-1:0] addr, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (addr)
            REG_WIRE_COLOR: sh_wire_color = data;
            REG_BASE_COLOR: sh_base_color = data;
            REG_WIRE_WIDTH: sh_wire_width = data[14:0];
            default:        sh_line_count = data[6:0];
        endcase
    endtask

    function automatic logic signed [15:0] rand_coord(bit full);
        if (full) return $urandom;
        return $urandom_range(0, 16383) - 8192;
    endfunction

    task automatic load_random(int slot);
        logic signed [15:0] org [3];
        logic signed [15:0] dir [3];
        bit full;
        full = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < 3; k++) begin
            org[k] = rand_coord(full);
            dir[k] = rand_coord(full);
        end
        // some zero-length segments
        if ($urandom_range(0, 11) == 0) foreach (dir[k]) dir[k] = '0;
        load_seg(slot, org, dir);
    endtask

    // a point near a chosen active segment, else anywhere
    task automatic query_random();
        logic signed [15:0] pt [3];
        int cnt, slot, f, spread, val;
        cnt = (sh_line_count > MAX_SEG) ? MAX_SEG : sh_line_count;
        if (cnt > 0 && $urandom_range(0, 9) < 7) begin
            slot   = $urandom_range(0, cnt - 1);
            f      = $urandom_range(0, 20) - 2;
            spread = sh_wire_width + 4;
            for (int k = 0; k < 3; k++) begin
                val = tab_org[slot][k] + (tab_dir[slot][k] * f) / 16
                      + int'($urandom_range(0, 2 * spread)) - spread;
                pt[k] = val[15:0];
            end
        end else begin
            foreach (pt[k]) pt[k] = $urandom;
        end
        query_pt(pt);
    endtask

    // reset values, no table reads
    task automatic test_reset_defaults();
        logic signed [15:0] pt [3];
        sh_wire_color = 32'hFFFF_FFFF;
        sh_base_color = '0;
        sh_wire_width = 15'd256;
        sh_line_count = '0;
        pt = '{16'sh7FFF, 16'sh8000, 16'sh0000};
        query_pt(pt);
        pt = '{16'sh8000, 16'sh7FFF, 16'shFFFF};
        query_pt(pt);
        wait_quiet();
    endtask

    // every slot written before any read
    task automatic test_table_fill();
        for (int i = 0; i < MAX_SEG; i++) load_random(i);
        wait_quiet();
    endtask

    // bounds of t, strict width, zero length, zero width, extremes
    task automatic test_directed();
        logic signed [15:0] org [3];
        logic signed [15:0] dir [3];
        logic signed [15:0] pt [3];
        org = '{16'sd0, 16'sd0, 16'sd0};
        dir = '{16'sd256, 16'sd0, 16'sd0};
        load_seg(0, org, dir);
        org = '{16'sd100, 16'sd100, 16'sd100};
        dir = '{16'sd0, 16'sd0, 16'sd0};
        load_seg(1, org, dir);
        org = '{16'sh8000, 16'sh8000, 16'sh8000};
        dir = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        load_seg(2, org, dir);
        wait_quiet();
        write_reg(REG_LINE_COUNT, 32'd1);
        pt = '{16'sd128, 16'sd100, 16'sd0};   query_pt(pt);
        pt = '{16'sd128, 16'sd256, 16'sd0};   query_pt(pt);
        pt = '{16'sd128, 16'sd255, 16'sd0};   query_pt(pt);
        pt = '{-16'sd1, 16'sd0, 16'sd0};      query_pt(pt);
        pt = '{16'sd257, 16'sd0, 16'sd0};     query_pt(pt);
        pt = '{16'sd0, 16'sd0, 16'sd0};       query_pt(pt);
        pt = '{16'sd256, 16'sd0, 16'sd0};     query_pt(pt);
        wait_quiet();
        // zero-length slot ahead of the extreme one
        write_reg(REG_LINE_COUNT, 32'd3);
        write_reg(REG_WIRE_COLOR, 32'h0000_0000);
        write_reg(REG_BASE_COLOR, 32'hFFFF_FFFF);
        pt = '{16'sd100, 16'sd100, 16'sd100}; query_pt(pt);
        pt = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}; query_pt(pt);
        pt = '{16'sh8000, 16'sh8000, 16'sh8000}; query_pt(pt);
        wait_quiet();
        write_reg(REG_WIRE_WIDTH, 32'd32767);
        write_reg(REG_LINE_COUNT, 32'd127);
        write_reg(REG_WIRE_COLOR, 32'hA5C3_0F81);
        write_reg(REG_BASE_COLOR, 32'h5A3C_F07E);
        pt = '{16'sh8000, 16'sh7FFF, 16'sh0000}; query_pt(pt);
        pt = '{16'sh7FFF, 16'sh8000, 16'sh7FFF}; query_pt(pt);
        wait_quiet();
        write_reg(REG_WIRE_WIDTH, 32'd0);
        pt = '{16'sd128, 16'sd0, 16'sd0};     query_pt(pt);
        pt = '{16'sd0, 16'sd0, 16'sd0};       query_pt(pt);
        wait_quiet();
    endtask

    // phases of random settings with mixed loads and queries
    task automatic test_random();
        int sel;
        for (int ph = 0; ph < 10; ph++) begin
            no_idle = (ph % 4 == 3);
            sel = $urandom_range(0, 9);
            if (sel == 0)      write_reg(REG_WIRE_WIDTH, 32'd0);
            else if (sel == 1) write_reg(REG_WIRE_WIDTH, 32'd32767);
            else               write_reg(REG_WIRE_WIDTH, $urandom_range(1, 3000));
            sel = $urandom_range(0, 9);
            if (sel == 0)      write_reg(REG_LINE_COUNT, 32'd0);
            else if (sel == 1) write_reg(REG_LINE_COUNT, $urandom_range(65, 127));
            else if (sel == 2) write_reg(REG_LINE_COUNT, 32'd64);
            else               write_reg(REG_LINE_COUNT, $urandom_range(1, 64));
            write_reg(REG_WIRE_COLOR, $urandom);
            write_reg(REG_BASE_COLOR, $urandom);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 9) < 3) load_random($urandom_range(0, 63));
                else                          query_random();
            end
            wait_quiet();
        end
        no_idle = 1'b0;
    endtask

    // result stream: random back-pressure
    initial begin
        m_axis_tready = 1'b0;
        out_stall     = 0;
        forever begin
            @(negedge i_clk);
            if (out_stall > 0) begin
                m_axis_tready <= 1'b0;
                out_stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3) out_stall = gap_len();
            end
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (shade_q.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                t_shade e;
                e = shade_q.pop_front();
                if (m_axis_tdata !== e.color)
                    report_mismatch($sformatf("color %h, wanted %h", m_axis_tdata, e.color));
                if (m_axis_tuser !== e.hit)
                    report_mismatch($sformatf("hit %b, wanted %b", m_axis_tuser, e.hit));
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        err_count     = 0;
        no_idle       = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_table_fill();
        test_directed();
        test_random();
        wait_quiet();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
